// ----- sv/color_model_to_rgb_top_macros.svh -----
// Assertion helpers, clocked on clk and disabled during reset.
`ifndef COLOR_MODEL_TO_RGB_TOP_MACROS_SVH
`define COLOR_MODEL_TO_RGB_TOP_MACROS_SVH

// Same-cycle implication.
`define CMTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CMTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cmtr_pkg.sv -----
`timescale 1ns / 1ps

package cmtr_pkg;

    localparam int HUE_BITS    = 13;
    localparam int FRAC_BITS   = 10;
    // 60 degrees in 1/16 degree units = 15 * 2^6
    localparam int SECTOR_POW  = 6;
    localparam int SECTOR_ODD  = 15;
    localparam int HUE_SECTOR  = SECTOR_ODD << SECTOR_POW;
    localparam int HUE_FULL    = 6 * HUE_SECTOR;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_RGB = 2'd0;
    localparam cmd_t CMD_CMY = 2'd1;
    localparam cmd_t CMD_HSV = 2'd2;
    localparam cmd_t CMD_BAD = 2'd3;

    typedef logic [2:0] sector_t;
    localparam sector_t SECT_RED     = 3'd0;
    localparam sector_t SECT_YELLOW  = 3'd1;
    localparam sector_t SECT_GREEN   = 3'd2;
    localparam sector_t SECT_CYAN    = 3'd3;
    localparam sector_t SECT_BLUE    = 3'd4;
    localparam sector_t SECT_MAGENTA = 3'd5;

    typedef struct packed {
        logic    err;
        logic    direct;   // final color known at decode, no hsv math needed
        sector_t sector;
    } ctl_t;

endpackage

// ----- sv/cmtr_decode.sv -----
`timescale 1ns / 1ps

module cmtr_decode
    import cmtr_pkg::*;
#(
    parameter int CB     = 12,
    parameter int A_BITS = 13
)
(
    input  logic                 clk,
    input  logic                 en,
    input  cmd_t                 command,
    input  logic [A_BITS-1:0]    chan_a,
    input  logic [CB-1:0]        chan_b,
    input  logic [CB-1:0]        chan_c,
    output ctl_t                 ctl,
    output logic [CB-1:0]        value,
    output logic [CB-1:0]        sat,
    output logic [FRAC_BITS-1:0] frac,
    output logic [CB-1:0]        dir_r,
    output logic [CB-1:0]        dir_g,
    output logic [CB-1:0]        dir_b
);

    localparam logic [CB-1:0]     ONE      = {CB{1'b1}};
    localparam logic [A_BITS-1:0] ONE_A    = A_BITS'((64'd1 << CB) - 64'd1);
    localparam logic [A_BITS-1:0] FULL_A   = A_BITS'(HUE_FULL);
    localparam logic [HUE_BITS-1:0] FULL_H = HUE_BITS'(HUE_FULL);

    ctl_t                 ctl_reg, ctl_next;
    logic [CB-1:0]        value_reg, sat_reg;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [CB-1:0]        dir_r_reg, dir_g_reg, dir_b_reg;
    logic [CB-1:0]        dir_r_next, dir_g_next, dir_b_next;
    logic [HUE_BITS-1:0]  hue;
    logic                 a_over_one;
    logic                 hue_over;
    sector_t              sector_next;

    assign a_over_one = (chan_a > ONE_A);
    assign hue_over   = (chan_a > FULL_A);
    // a full circle is the same hue as zero
    assign hue = (chan_a[HUE_BITS-1:0] == FULL_H) ? '0 : chan_a[HUE_BITS-1:0];

    always_comb
    begin
        ctl_next.sector = sector_next;
        ctl_next.err    = 1'b0;
        ctl_next.direct = 1'b1;
        dir_r_next      = '0;
        dir_g_next      = '0;
        dir_b_next      = '0;
        unique case (command)
            CMD_RGB:
            begin
                ctl_next.err = a_over_one;
                dir_r_next   = chan_a[CB-1:0];
                dir_g_next   = chan_b;
                dir_b_next   = chan_c;
            end
            CMD_CMY:
            begin
                ctl_next.err = a_over_one;
                dir_r_next   = ONE - chan_a[CB-1:0];
                dir_g_next   = ONE - chan_b;
                dir_b_next   = ONE - chan_c;
            end
            CMD_HSV:
            begin
                ctl_next.err    = hue_over;
                ctl_next.direct = hue_over || (chan_b == '0);
                // gray when saturation is zero
                dir_r_next      = chan_c;
                dir_g_next      = chan_c;
                dir_b_next      = chan_c;
            end
            CMD_BAD:
            begin
                ctl_next.err = 1'b1;
            end
        endcase
        if (ctl_next.err)
        begin
            ctl_next.direct = 1'b1;
            dir_r_next      = '0;
            dir_g_next      = '0;
            dir_b_next      = '0;
        end
    end

    always_comb
    begin
        priority if (hue < HUE_BITS'(HUE_SECTOR))
        begin
            sector_next = SECT_RED;
            frac_next   = hue[FRAC_BITS-1:0];
        end
        else if (hue < HUE_BITS'(2 * HUE_SECTOR))
        begin
            sector_next = SECT_YELLOW;
            frac_next   = FRAC_BITS'(hue - HUE_BITS'(HUE_SECTOR));
        end
        else if (hue < HUE_BITS'(3 * HUE_SECTOR))
        begin
            sector_next = SECT_GREEN;
            frac_next   = FRAC_BITS'(hue - HUE_BITS'(2 * HUE_SECTOR));
        end
        else if (hue < HUE_BITS'(4 * HUE_SECTOR))
        begin
            sector_next = SECT_CYAN;
            frac_next   = FRAC_BITS'(hue - HUE_BITS'(3 * HUE_SECTOR));
        end
        else if (hue < HUE_BITS'(5 * HUE_SECTOR))
        begin
            sector_next = SECT_BLUE;
            frac_next   = FRAC_BITS'(hue - HUE_BITS'(4 * HUE_SECTOR));
        end
        else
        begin
            sector_next = SECT_MAGENTA;
            frac_next   = FRAC_BITS'(hue - HUE_BITS'(5 * HUE_SECTOR));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg   <= ctl_next;
            value_reg <= chan_c;
            sat_reg   <= chan_b;
            frac_reg  <= frac_next;
            dir_r_reg <= dir_r_next;
            dir_g_reg <= dir_g_next;
            dir_b_reg <= dir_b_next;
        end
    end

    assign ctl   = ctl_reg;
    assign value = value_reg;
    assign sat   = sat_reg;
    assign frac  = frac_reg;
    assign dir_r = dir_r_reg;
    assign dir_g = dir_g_reg;
    assign dir_b = dir_b_reg;

endmodule

// ----- sv/cmtr_scale.sv -----
`timescale 1ns / 1ps

// round(V * (D - S*w) / D) with D = ONE * HUE_SECTOR, four register stages.
module cmtr_scale
    import cmtr_pkg::*;
#(
    parameter int CB = 12
)
(
    input  logic                 clk,
    input  logic [3:0]           stage_en,
    input  logic [CB-1:0]        value,
    input  logic [CB-1:0]        sat,
    input  logic [FRAC_BITS-1:0] weight,
    output logic [CB-1:0]        result
);

    localparam longint unsigned ONE_L   = (64'd1 << CB) - 64'd1;
    localparam longint unsigned DEN_L   = ONE_L * HUE_SECTOR;
    localparam longint unsigned HALF_L  = DEN_L / 2;
    localparam longint unsigned ODD_L   = ONE_L * SECTOR_ODD;
    localparam int              SW_W    = CB + FRAC_BITS;
    localparam int              VF_W    = 2 * CB + FRAC_BITS;
    localparam int              N1_W    = VF_W - SECTOR_POW;
    localparam int              E_W     = CB + 4;
    localparam int              SHIFT   = N1_W;
    localparam int              M_W     = CB + 1;
    // reciprocal of ONE*15 scaled so the estimate is low by at most one
    localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / ODD_L;

    localparam logic [SW_W-1:0] DEN   = SW_W'(DEN_L);
    localparam logic [VF_W-1:0] HALF  = VF_W'(HALF_L);
    localparam logic [E_W-1:0]  ODD   = E_W'(ODD_L);
    localparam logic [M_W-1:0]  RECIP = M_W'(RECIP_L);

    logic [SW_W-1:0]       sw_reg;
    logic [CB-1:0]         v_a_reg;
    logic [SW_W-1:0]       factor;
    logic [VF_W-1:0]       vf_reg;
    logic [VF_W-1:0]       n_sum;
    logic [N1_W-1:0]       n1_next, n1_reg;
    logic [N1_W+M_W-1:0]   est_prod;
    logic [CB-1:0]         est_next, est_reg;
    logic [N1_W-1:0]       back_prod;
    logic [N1_W-1:0]       rem;
    logic [CB-1:0]         result_reg, result_next;

    assign factor   = DEN - sw_reg;
    // the 2^6 part of the divisor is a plain shift
    assign n_sum    = vf_reg + HALF;
    assign n1_next  = n_sum[VF_W-1:SECTOR_POW];
    assign est_prod = (N1_W + M_W)'(n1_next) * (N1_W + M_W)'(RECIP);
    assign est_next = est_prod[SHIFT +: CB];

    assign back_prod   = N1_W'(est_reg) * N1_W'(ODD);
    assign rem         = n1_reg - back_prod;
    assign result_next = est_reg + CB'(rem >= N1_W'(ODD));

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            sw_reg  <= SW_W'(sat) * SW_W'(weight);
            v_a_reg <= value;
        end
        if (stage_en[1])
        begin
            vf_reg <= VF_W'(v_a_reg) * VF_W'(factor);
        end
        if (stage_en[2])
        begin
            n1_reg  <= n1_next;
            est_reg <= est_next;
        end
        if (stage_en[3])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- sv/color_model_to_rgb_top.sv -----
`timescale 1ns / 1ps

// Color model to RGB converter. Each request carries a mode (rgb, cmy, hsv)
// and a triple; rgb passes through, cmy is inverted per channel, hsv goes
// through the six-sector conversion with hue in 1/16 degree (0..5760) and
// components where all ones means 1.0. Invalid modes or out-of-range fields
// give range_error with a black result. Throughput is one request per clock
// while out_ready is high. Stages: one decode stage, four in each of the
// three scale lanes (saturation product, value product, reciprocal estimate
// of the divide by ONE*960, remainder correction) and the output register.
// Ready follows pipeline occupancy, so bubbles are squeezed out under stall.
module color_model_to_rgb_top
    import cmtr_pkg::*;
#(
    parameter int COMPONENT_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            command,
    input  logic [((COMPONENT_BITS + 1 > HUE_BITS) ? COMPONENT_BITS + 1 : HUE_BITS)-1:0]
                                  chan_a,
    input  logic [COMPONENT_BITS-1:0] chan_b,
    input  logic [COMPONENT_BITS-1:0] chan_c,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COMPONENT_BITS-1:0] red,
    output logic [COMPONENT_BITS-1:0] green,
    output logic [COMPONENT_BITS-1:0] blue,
    output logic                  range_error
);

`include "color_model_to_rgb_top_macros.svh"

    localparam int CB     = COMPONENT_BITS;
    localparam int A_BITS = (CB + 1 > HUE_BITS) ? CB + 1 : HUE_BITS;
    localparam int NST    = 6;

    typedef struct packed {
        ctl_t          ctl;
        logic [CB-1:0] value;
        logic [CB-1:0] dir_r;
        logic [CB-1:0] dir_g;
        logic [CB-1:0] dir_b;
    } side_t;

    logic [NST-1:0]       valid_reg, valid_next;
    logic [NST-1:0]       vin;
    logic [NST:0]         rdy;
    logic [NST-1:0]       en;

    ctl_t                 ctl0;
    logic [CB-1:0]        value0, sat0, dir_r0, dir_g0, dir_b0;
    logic [FRAC_BITS-1:0] frac0;
    logic [FRAC_BITS-1:0] w_p, w_q, w_t;
    side_t                side0;
    side_t                side_reg [1:4];
    logic [CB-1:0]        p_res, q_res, t_res;

    logic [CB-1:0]        red_reg, green_reg, blue_reg;
    logic                 err_reg;
    logic [CB-1:0]        red_next, green_next, blue_next;

    // ---------------- pipeline control ----------------
    assign vin = {valid_reg[NST-2:0], in_valid};

    always_comb
    begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign en         = rdy[NST-1:0] & vin;
    assign valid_next = (rdy[NST-1:0] & vin) | (~rdy[NST-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NST-1];

    // ---------------- stage 0: decode ----------------
    cmtr_decode #(
        .CB     (CB),
        .A_BITS (A_BITS)
    ) u_decode (
        .clk     (clk),
        .en      (en[0]),
        .command (command),
        .chan_a  (chan_a),
        .chan_b  (chan_b),
        .chan_c  (chan_c),
        .ctl     (ctl0),
        .value   (value0),
        .sat     (sat0),
        .frac    (frac0),
        .dir_r   (dir_r0),
        .dir_g   (dir_g0),
        .dir_b   (dir_b0)
    );

    // ---------------- stages 1..4: p, q, t lanes ----------------
    assign w_p = FRAC_BITS'(HUE_SECTOR);
    assign w_q = frac0;
    assign w_t = FRAC_BITS'(HUE_SECTOR) - frac0;

    cmtr_scale #(.CB(CB)) u_scale_p (
        .clk      (clk),
        .stage_en (en[4:1]),
        .value    (value0),
        .sat      (sat0),
        .weight   (w_p),
        .result   (p_res)
    );

    cmtr_scale #(.CB(CB)) u_scale_q (
        .clk      (clk),
        .stage_en (en[4:1]),
        .value    (value0),
        .sat      (sat0),
        .weight   (w_q),
        .result   (q_res)
    );

    cmtr_scale #(.CB(CB)) u_scale_t (
        .clk      (clk),
        .stage_en (en[4:1]),
        .value    (value0),
        .sat      (sat0),
        .weight   (w_t),
        .result   (t_res)
    );

    assign side0.ctl   = ctl0;
    assign side0.value = value0;
    assign side0.dir_r = dir_r0;
    assign side0.dir_g = dir_g0;
    assign side0.dir_b = dir_b0;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg[1] <= side0;
        end
        for (int i = 2; i <= 4; i++)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- stage 5: sector placement, output ----------------
    always_comb
    begin
        red_next   = side_reg[4].dir_r;
        green_next = side_reg[4].dir_g;
        blue_next  = side_reg[4].dir_b;
        if (!side_reg[4].ctl.direct)
        begin
            unique case (side_reg[4].ctl.sector)
                SECT_RED:
                begin
                    red_next = side_reg[4].value; green_next = t_res; blue_next = p_res;
                end
                SECT_YELLOW:
                begin
                    red_next = q_res; green_next = side_reg[4].value; blue_next = p_res;
                end
                SECT_GREEN:
                begin
                    red_next = p_res; green_next = side_reg[4].value; blue_next = t_res;
                end
                SECT_CYAN:
                begin
                    red_next = p_res; green_next = q_res; blue_next = side_reg[4].value;
                end
                SECT_BLUE:
                begin
                    red_next = t_res; green_next = p_res; blue_next = side_reg[4].value;
                end
                SECT_MAGENTA:
                begin
                    red_next = side_reg[4].value; green_next = p_res; blue_next = q_res;
                end
                default:
                begin
                    red_next = '0; green_next = '0; blue_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            err_reg   <= side_reg[4].ctl.err;
        end
    end

    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign range_error = err_reg;

    // ---------------- assertions ----------------
    `CMTR_ASSERT_NOW(a_err_black, out_valid && range_error, red == '0 && green == '0 && blue == '0, "rejected request produced a nonzero color")
    `CMTR_ASSERT_NOW(a_scale_bound, valid_reg[4] && !side_reg[4].ctl.direct, p_res <= side_reg[4].value && q_res <= side_reg[4].value && t_res <= side_reg[4].value, "scaled component exceeds value")
    `CMTR_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, valid_reg[0], "accepted request did not enter decode stage")

endmodule
